@@ src/alct_pkg.sv @@
package alct_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TYPE_W   = 24;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned WALK_W   = 25;  // external_base + 24-bit type, plus one
  localparam int unsigned FLAG_POS = 31;

  typedef enum logic [2:0] {
    ST_WRITTEN        = 3'd0,
    ST_ALLOWED        = 3'd1,
    ST_ZERO_REPEAT    = 3'd2,
    ST_TYPE_MISMATCH  = 3'd3,
    ST_COUNT_EXCEEDED = 3'd4,
    ST_LIST_ENDED     = 3'd5,
    ST_BEYOND_TABLE   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_REPEAT_START  = 2'd0,
    REG_REPEAT_LENGTH = 2'd1,
    REG_EXTERNAL_BASE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_ADDR,
    S_WORD,
    S_WADDR,
    S_WENTRY,
    S_FINISH
  } state_t;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } rem_req_t;

  // response from the remainder unit
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] rem;
  } rem_rsp_t;

  // (offset mod 4) / size, size 0 read as 1
  function automatic logic [1:0] sub_offset(input logic [1:0] lo, input logic [SIZE_W-1:0] sz);
    logic [1:0] res;
    res = 2'd0;
    if (sz <= 16'd1) begin
      res = lo;
    end else if (sz == 16'd2) begin
      res = {1'b0, lo[1]};
    end else if (sz == 16'd3) begin
      res = (lo == 2'd3) ? 2'd1 : 2'd0;
    end
    return res;
  endfunction

endpackage

@@ src/alct_ram.sv @@
module alct_ram import alct_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/alct_rem.sv @@
// restoring remainder, one quotient bit per cycle
module alct_rem import alct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [4:0]        cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] dq;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   acc_next;

  always_comb begin
    trial = {acc, dq[WORD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      acc_next = trial - {1'b0, dvs};
    end else begin
      acc_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      acc <= acc_next[WORD_W-1:0];
      dq  <= {dq[WORD_W-2:0], 1'b0};
    end
  end

  assign rsp = {done, acc};

endmodule

@@ src/alloc_type_layout_check_core.sv @@
// Write beat: IDLE, FINISH, then the result register; check beat on an inline word: IDLE,
// ADDR, WORD, FINISH, or IDLE, FINISH on a zero repeat length and IDLE, ADDR, FINISH on a
// word past the table. A fold adds FOLD (bit-serial remainder, one bit a cycle); an external
// list adds WADDR, WENTRY per entry read, one more WADDR if it runs off. One item in flight:
// the next beat is taken the cycle after the result is registered; FINISH holds on out_stall.
// rst: synchronous, active high; control idles, registers reset, layout table not cleared.
module alloc_type_layout_check_core import alct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  entry_index,
  input  logic [31:0] entry_word,
  input  logic [31:0] byte_offset,
  input  logic [23:0] target_type,
  input  logic [15:0] target_size,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = (AW > 8) ? AW : 8;

  // registers
  logic [WORD_W-1:0] repeat_start;
  logic [WORD_W-1:0] repeat_length;
  logic [7:0]        external_base;

  // per-item working state
  state_t            state, state_next;
  status_t           res, res_next;
  logic [WORD_W-1:0] off, off_next;
  logic [TYPE_W-1:0] ttype, ttype_next;
  logic [SIZE_W-1:0] tsize, tsize_next;
  logic [1:0]        sub, sub_next;
  logic [WALK_W-1:0] widx, widx_next;

  // table RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  rem_req_t rreq;
  rem_rsp_t rrsp;

  logic          in_acc;
  logic          out_free;
  logic [XW-1:0] wr_ext;
  logic          wr_in_range;
  logic [31:0]   word_idx;
  logic [2:0]    need;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  // output slot can take a new result this cycle
  assign out_free  = !out_valid || !out_stall;

  assign wr_ext      = XW'(entry_index);
  assign wr_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
  assign ram_we      = in_acc && !mode && wr_in_range;
  assign ram_waddr   = wr_ext[AW-1:0];
  assign word_idx    = {2'b00, off[31:2]};
  assign need        = 3'(sub) + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_start  <= '1;
      repeat_length <= '0;
      external_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPEAT_START:  repeat_start  <= cfg_data;
        REG_REPEAT_LENGTH: repeat_length <= cfg_data;
        REG_EXTERNAL_BASE: external_base <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  alct_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(entry_word),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  alct_rem u_rem (
    .clk(clk),
    .rst(rst),
    .req(rreq),
    .rsp(rrsp)
  );

  always_comb begin
    state_next    = state;
    res_next      = res;
    off_next      = off;
    ttype_next    = ttype;
    tsize_next    = tsize;
    sub_next      = sub;
    widx_next     = widx;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    rreq.start    = 1'b0;
    rreq.dividend = byte_offset - repeat_start;
    rreq.divisor  = repeat_length;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          off_next   = byte_offset;
          ttype_next = target_type;
          tsize_next = target_size;
          if (!mode) begin
            res_next   = ST_WRITTEN;
            state_next = S_FINISH;
          end else if (byte_offset >= repeat_start) begin
            if (repeat_length == '0) begin
              res_next   = ST_ZERO_REPEAT;
              state_next = S_FINISH;
            end else begin
              rreq.start = 1'b1;
              state_next = S_FOLD;
            end
          end else begin
            state_next = S_ADDR;
          end
        end
      end
      S_FOLD: begin
        if (rrsp.done) begin
          off_next   = repeat_start + rrsp.rem;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        sub_next = sub_offset(off[1:0], tsize);
        if (word_idx >= 32'(TABLE_DEPTH)) begin
          res_next   = ST_BEYOND_TABLE;
          state_next = S_FINISH;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = off[AW+1:2];
          state_next = S_WORD;
        end
      end
      S_WORD: begin
        if (!ram_rdata[FLAG_POS]) begin
          // inline word: type first, then multiplicity
          if (ram_rdata[TYPE_W-1:0] != ttype) begin
            res_next = ST_TYPE_MISMATCH;
          end else if (need > ram_rdata[30:28]) begin
            res_next = ST_COUNT_EXCEEDED;
          end else begin
            res_next = ST_ALLOWED;
          end
          state_next = S_FINISH;
        end else begin
          widx_next  = WALK_W'(external_base) + WALK_W'(ram_rdata[TYPE_W-1:0]);
          state_next = S_WADDR;
        end
      end
      S_WADDR: begin
        if (32'(widx) >= 32'(TABLE_DEPTH)) begin
          res_next   = ST_BEYOND_TABLE;
          state_next = S_FINISH;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = widx[AW-1:0];
          state_next = S_WENTRY;
        end
      end
      S_WENTRY: begin
        if (ram_rdata[TYPE_W-1:0] == ttype && ram_rdata[30:28] == {1'b0, sub}) begin
          res_next   = ST_ALLOWED;
          state_next = S_FINISH;
        end else if (ram_rdata[FLAG_POS]) begin
          res_next   = ST_LIST_ENDED;
          state_next = S_FINISH;
        end else begin
          widx_next  = widx + WALK_W'(1);
          state_next = S_WADDR;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res   <= res_next;
    off   <= off_next;
    ttype <= ttype_next;
    tsize <= tsize_next;
    sub   <= sub_next;
    widx  <= widx_next;
  end

  // output register: loaded as the FSM leaves FINISH
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      status <= res;
    end
  end

  // remainder completes only while the FSM waits on it
  a_rem_done_fold: assert property (@(posedge clk) disable iff (rst)
    rrsp.done |-> state == S_FOLD)
    else $error("remainder done outside fold");

  // table reads only from the address states
  a_read_state: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (state == S_ADDR || state == S_WADDR))
    else $error("table read from wrong state");

  // table writes only on an accepted write beat
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE && !mode))
    else $error("table write outside idle");

  // a finished result reaches the output register once the slot is free
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not delivered");

  // word lookup read always follows an address cycle
  a_word_after_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_WORD |-> $past(state) == S_ADDR)
    else $error("word state without read");

endmodule
